FILE: rtl/core/line_box_face_intersect_defines.svh
// Assertion macros for the line/box face intersection RTL.
`ifndef LINE_BOX_FACE_INTERSECT_DEFINES_SVH
`define LINE_BOX_FACE_INTERSECT_DEFINES_SVH
`ifndef SYNTHESIS
`define LBFI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LBFI_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define LBFI_ASSERT(lbl, prop, msg)
`define LBFI_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/lbfi_pkg.sv
// Types, constants and face tables for the line/box face intersection block.
`default_nettype none
package lbfi_pkg;
   localparam int CoordBits     = 32;
   localparam int FracBits      = 16;
   localparam int TolBits       = 16;
   localparam int IntBits       = CoordBits - 1 - FracBits;
   localparam int DivSteps      = CoordBits - 1;
   localparam int StepsPerStage = 2;
   localparam int DivStages     = (DivSteps + StepsPerStage - 1) / StepsPerStage;

   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   localparam logic [2:0] RegBoxLowX  = 3'd0;
   localparam logic [2:0] RegBoxLowY  = 3'd1;
   localparam logic [2:0] RegBoxLowZ  = 3'd2;
   localparam logic [2:0] RegBoxHighX = 3'd3;
   localparam logic [2:0] RegBoxHighY = 3'd4;
   localparam logic [2:0] RegBoxHighZ = 3'd5;
   localparam logic [2:0] RegTol      = 3'd6;

   typedef enum logic [2:0] {
      FACE_ZLOW  = 3'd0,
      FACE_ZHIGH = 3'd1,
      FACE_XLOW  = 3'd2,
      FACE_XHIGH = 3'd3,
      FACE_YLOW  = 3'd4,
      FACE_YHIGH = 3'd5
   } face_type;

   typedef struct packed {
      logic [2:0][CoordBits-1:0] box_lo;
      logic [2:0][CoordBits-1:0] box_hi;
      logic [TolBits-1:0]        tol;
   } cfg_type;

   typedef struct packed {
      logic [2:0][CoordBits-1:0] o;
      logic [2:0][CoordBits-1:0] d;
      face_type                  face;
      logic                      ray_end;
      logic                      skip;
      logic [1:0]                axis;
      logic [CoordBits-1:0]      p;
   } token_type;

   typedef struct packed {
      token_type              tok;
      logic [CoordBits-1:0]   dmag;
      logic                   neg;
      logic                   ovf;
      logic [CoordBits-1:0]   rem;
      logic [DivSteps-1:0]    dvd;
      logic [DivSteps-1:0]    quo;
   } div_type;

   typedef struct packed {
      logic                      hit;
      face_type                  face;
      logic [2:0][CoordBits-1:0] pos;
      logic                      ray_end;
   } result_type;

   function automatic logic [1:0] face_axis(face_type f);
      logic [1:0] a;
      unique case (f)
         FACE_ZLOW, FACE_ZHIGH: a = AxisZ;
         FACE_XLOW, FACE_XHIGH: a = AxisX;
         FACE_YLOW, FACE_YHIGH: a = AxisY;
         default:               a = AxisZ;
      endcase
      return a;
   endfunction

   function automatic logic face_high(face_type f);
      logic h;
      unique case (f)
         FACE_ZHIGH, FACE_XHIGH, FACE_YHIGH: h = 1'b1;
         default:                            h = 1'b0;
      endcase
      return h;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/lbfi_prep.sv
// Ray holding register, face sequencer and plane-distance stage.
`default_nettype none
module lbfi_prep (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire lbfi_pkg::cfg_type    cfg,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [191:0]         req_tdata,
   output logic                      div_valid,
   output lbfi_pkg::div_type         div_out
);
   localparam int CB = lbfi_pkg::CoordBits;

   logic                     ray_valid_ff;
   logic [2:0][CB-1:0]       ray_o_ff, ray_d_ff;
   lbfi_pkg::face_type       face_ff, face_in;
   logic                     tok_valid_ff;
   lbfi_pkg::token_type      tok_ff, tok_in;
   logic                     div_valid_ff;
   lbfi_pkg::div_type        div_ff, div_in;

   logic                     last_face;
   logic                     take;
   logic [CB-1:0]            da, oa, dmag;
   logic [CB:0]              num, nmag;

   assign last_face  = (face_ff == lbfi_pkg::FACE_YHIGH);
   assign req_tready = !ray_valid_ff || (adv && last_face);
   assign take       = req_tvalid && req_tready;

   always_comb begin
      face_in = face_ff;
      if (take) begin
         face_in = lbfi_pkg::FACE_ZLOW;
      end else if (ray_valid_ff && adv && !last_face) begin
         face_in = lbfi_pkg::face_type'(face_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_valid_ff <= 1'b0;
      end else if (take) begin
         ray_valid_ff <= 1'b1;
      end else if (adv && last_face) begin
         ray_valid_ff <= 1'b0;
      end
      if (take) begin
         ray_o_ff <= req_tdata[3*CB-1:0];
         ray_d_ff <= req_tdata[6*CB-1:3*CB];
      end
      face_ff <= face_in;
   end

   always_comb begin
      tok_in         = '0;
      tok_in.o       = ray_o_ff;
      tok_in.d       = ray_d_ff;
      tok_in.face    = face_ff;
      tok_in.ray_end = last_face;
      tok_in.axis    = lbfi_pkg::face_axis(face_ff);
      tok_in.p       = lbfi_pkg::face_high(face_ff) ? cfg.box_hi[tok_in.axis]
                                                    : cfg.box_lo[tok_in.axis];
   end

   always_comb begin
      da   = tok_ff.d[tok_ff.axis];
      oa   = tok_ff.o[tok_ff.axis];
      num  = {tok_ff.p[CB-1], tok_ff.p} - {oa[CB-1], oa};
      nmag = num[CB] ? (CB+1)'(0) - num : num;
      dmag = da[CB-1] ? CB'(0) - da : da;
      div_in          = '0;
      div_in.tok      = tok_ff;
      div_in.tok.skip = (dmag <= {{(CB-lbfi_pkg::TolBits){1'b0}}, cfg.tol})
                        || ((num != '0) && (num[CB] != da[CB-1]));
      div_in.dmag     = dmag;
      div_in.neg      = num[CB] ^ da[CB-1];
      div_in.ovf      = {{(lbfi_pkg::IntBits){1'b0}}, nmag}
                        >= {1'b0, dmag, {(lbfi_pkg::IntBits){1'b0}}};
      div_in.rem      = CB'(nmag >> lbfi_pkg::IntBits);
      div_in.dvd      = {nmag[lbfi_pkg::IntBits-1:0], {(lbfi_pkg::FracBits){1'b0}}};
      div_in.quo      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
         div_valid_ff <= 1'b0;
      end else if (adv) begin
         tok_valid_ff <= ray_valid_ff;
         div_valid_ff <= tok_valid_ff;
      end
      if (adv) begin
         tok_ff <= tok_in;
         div_ff <= div_in;
      end
   end

   assign div_valid = div_valid_ff;
   assign div_out   = div_ff;
endmodule
`default_nettype wire

FILE: rtl/core/lbfi_div.sv
// Pipelined restoring divider for the ray parameter, two quotient bits a stage (one in the last).
`default_nettype none
module lbfi_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire lbfi_pkg::div_type  in_data,
   output logic                    out_valid,
   output lbfi_pkg::div_type       out_data
);
   localparam int NS = lbfi_pkg::DivStages;
   localparam int SP = lbfi_pkg::StepsPerStage;
   localparam int CB = lbfi_pkg::CoordBits;

   logic              vld_ff [NS];
   lbfi_pkg::div_type st_ff [NS];
   logic              vld_src [NS];
   lbfi_pkg::div_type st_src [NS];
   lbfi_pkg::div_type st_in [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign vld_src[s] = in_valid;
         assign st_src[s]  = in_data;
      end else begin : g_next
         assign vld_src[s] = vld_ff[s-1];
         assign st_src[s]  = st_ff[s-1];
      end

      always_comb begin
         logic [CB:0] r2;
         st_in[s] = st_src[s];
         for (int k = 0; k < SP; k++) begin
            if (s * SP + k < lbfi_pkg::DivSteps) begin
               r2 = {st_in[s].rem, st_in[s].dvd[lbfi_pkg::DivSteps-1]};
               st_in[s].dvd = st_in[s].dvd << 1;
               if (r2 >= {1'b0, st_in[s].dmag}) begin
                  r2 = r2 - {1'b0, st_in[s].dmag};
                  st_in[s].quo = {st_in[s].quo[lbfi_pkg::DivSteps-2:0], 1'b1};
               end else begin
                  st_in[s].quo = {st_in[s].quo[lbfi_pkg::DivSteps-2:0], 1'b0};
               end
               st_in[s].rem = r2[CB-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_src[s];
         end
         if (adv) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_data  = st_ff[NS-1];
endmodule
`default_nettype wire

FILE: rtl/core/lbfi_hit.sv
// Ray parameter clamp, hit point products, sums and box containment stages.
`default_nettype none
module lbfi_hit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire lbfi_pkg::cfg_type    cfg,
   input  wire logic                 in_valid,
   input  wire lbfi_pkg::div_type    in_data,
   output logic                      res_valid,
   output lbfi_pkg::result_type      res
);
   localparam int CB = lbfi_pkg::CoordBits;
   localparam int PW = 2 * CB - lbfi_pkg::FracBits;
   localparam logic [CB-1:0] NegLim = {1'b1, {(CB-1){1'b0}}};
   localparam logic [CB-1:0] PosLim = {1'b0, {(CB-1){1'b1}}};

   logic                     t_valid_ff, m_valid_ff, a_valid_ff, c_valid_ff;
   lbfi_pkg::token_type      t_tok_ff, m_tok_ff, a_tok_ff;
   logic [CB-1:0]            t_mag_ff, t_mag_in;
   logic                     t_neg_ff;
   logic [2:0][2*CB-1:0]     prod_ff, prod_in;
   logic [2:0]               pneg_ff, pneg_in;
   logic [2:0][CB-1:0]       pos_ff, pos_in;
   lbfi_pkg::result_type     res_ff, res_in;

   always_comb begin
      if (in_data.ovf) begin
         t_mag_in = NegLim;
      end else begin
         t_mag_in = {1'b0, in_data.quo};
      end
      if (!in_data.neg && t_mag_in > PosLim) begin
         t_mag_in = PosLim;
      end
   end

   always_comb begin
      logic [CB-1:0] dm;
      for (int b = 0; b < 3; b++) begin
         dm         = t_tok_ff.d[b][CB-1] ? CB'(0) - t_tok_ff.d[b] : t_tok_ff.d[b];
         prod_in[b] = t_mag_ff * dm;
         pneg_in[b] = t_neg_ff ^ t_tok_ff.d[b][CB-1];
      end
   end

   always_comb begin
      logic [PW-1:0] mag;
      logic [PW-1:0] lim;
      logic [CB-1:0] m;
      logic [CB+1:0] val, sum;
      for (int b = 0; b < 3; b++) begin
         mag = prod_ff[b][2*CB-1:lbfi_pkg::FracBits];
         lim = pneg_ff[b] ? PW'(NegLim) : PW'(PosLim);
         m   = (mag > lim) ? lim[CB-1:0] : mag[CB-1:0];
         val = pneg_ff[b] ? (CB+2)'(0) - {2'b00, m} : {2'b00, m};
         sum = {{2{m_tok_ff.o[b][CB-1]}}, m_tok_ff.o[b]} + val;
         if (sum[CB+1:CB-1] == 3'b000 || sum[CB+1:CB-1] == 3'b111) begin
            pos_in[b] = sum[CB-1:0];
         end else begin
            pos_in[b] = sum[CB+1] ? NegLim : PosLim;
         end
         if (2'(b) == m_tok_ff.axis) begin
            pos_in[b] = m_tok_ff.p;
         end
      end
   end

   always_comb begin
      logic signed [CB+1:0] v, lo, hi, tol;
      logic in_box;
      in_box = 1'b1;
      tol    = $signed({{(CB+2-lbfi_pkg::TolBits){1'b0}}, cfg.tol});
      for (int b = 0; b < 3; b++) begin
         v  = $signed({{2{pos_ff[b][CB-1]}}, pos_ff[b]});
         lo = $signed({{2{cfg.box_lo[b][CB-1]}}, cfg.box_lo[b]}) - tol;
         hi = $signed({{2{cfg.box_hi[b][CB-1]}}, cfg.box_hi[b]}) + tol;
         if (v < lo || v > hi) begin
            in_box = 1'b0;
         end
      end
      res_in.hit     = in_box && !a_tok_ff.skip;
      res_in.face    = a_tok_ff.face;
      res_in.pos     = pos_ff;
      res_in.ray_end = a_tok_ff.ray_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         t_valid_ff <= in_valid;
         m_valid_ff <= t_valid_ff;
         a_valid_ff <= m_valid_ff;
         c_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         t_tok_ff <= in_data.tok;
         t_mag_ff <= t_mag_in;
         t_neg_ff <= in_data.neg;
         m_tok_ff <= t_tok_ff;
         prod_ff  <= prod_in;
         pneg_ff  <= pneg_in;
         a_tok_ff <= m_tok_ff;
         pos_ff   <= pos_in;
         res_ff   <= res_in;
      end
   end

   assign res_valid = c_valid_ff;
   assign res       = res_ff;
endmodule
`default_nettype wire

FILE: rtl/core/lbfi_collect.sv
// Result collector: holds one hit back to mark the last item of each ray.
`default_nettype none
`include "line_box_face_intersect_defines.svh"
module lbfi_collect (
   input  wire logic                  clock,
   input  wire logic                  reset,
   output logic                       adv,
   input  wire logic                  res_valid,
   input  wire lbfi_pkg::result_type  res,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [103:0]               rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   logic                  out_valid_ff, out_valid_in;
   lbfi_pkg::result_type  out_ff, out_in;
   logic                  out_last_ff, out_last_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_final_ff, pend_final_in;
   lbfi_pkg::result_type  pend_ff, pend_in;
   logic                  out_free;

   assign out_free = !out_valid_ff || rsp_tready;
   assign adv      = out_free && !pend_final_ff;

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_in       = pend_ff;
      if (pend_final_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
         pend_final_in = 1'b0;
      end else if (adv && res_valid) begin
         if (res.hit && pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = pend_ff;
            out_last_in   = 1'b0;
            pend_in       = res;
            pend_final_in = res.ray_end;
         end else if (res.hit && res.ray_end) begin
            out_valid_in = 1'b1;
            out_in       = res;
            out_last_in  = 1'b1;
         end else if (res.hit) begin
            pend_valid_in = 1'b1;
            pend_in       = res;
         end else if (res.ray_end) begin
            out_valid_in  = 1'b1;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            if (pend_valid_ff) begin
               out_in = pend_ff;
            end else begin
               out_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
      end
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      pend_ff     <= pend_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.hit;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'b0, out_ff.pos[2], out_ff.pos[1], out_ff.pos[0], out_ff.face};

   `LBFI_ASSERT(a_final_has_pend, pend_final_ff |-> pend_valid_ff, "final without pending hit")
   `LBFI_ASSERT(a_final_drains, (pend_final_ff && out_free) |=> !pend_final_ff, "held final item not drained")
   `LBFI_ASSERT_NEVER(a_nohit_not_last, out_valid_ff && !out_ff.hit && !out_last_ff, "no-hit item without last")
   `LBFI_ASSERT(a_no_adv_final, pend_final_ff |-> !adv, "pipeline moved while final held")
endmodule
`default_nettype wire

FILE: rtl/core/line_box_face_intersect.sv
// Top level: configuration registers and the ray/box face intersection pipeline.
//
//  channel  role    payload
//  req_     in      tdata: origin x,y,z then direction x,y,z (32 bits each)
//  rsp_     out     tdata: face, hit x,y,z; tuser: hit_valid; tlast: last
//  csr_     cfg     box low x,y,z, box high x,y,z, tolerance at 4*i
//
//  One face enters the pipeline each cycle unless the pipeline is stalled; the
//  face sequencer steps a ray through its faces. A face then passes the token
//  and division-setup registers, the 16-stage divider and the clamp, product,
//  sum and containment stages; the collector holds a hit until a later hit or
//  the ray's last face. When face y-high and an earlier face both hit, the
//  collector holds the pipeline until it has emitted both items.
//  Reset is synchronous and clears all valid bits; registers return to a
//  unit box with a tolerance of one LSB. A stall on rsp_ freezes the pipeline.
`default_nettype none
module line_box_face_intersect (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [191:0]  req_tdata,   // origin_x,y,z, direction_x,y,z
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [103:0]       rsp_tdata,   // face, hit_x, hit_y, hit_z, pad
   output logic               rsp_tuser,   // hit_valid
   output logic               rsp_tlast,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [4:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   lbfi_pkg::cfg_type     cfg_ff;
   logic                  wr;
   logic [2:0]            idx;
   logic                  adv;
   logic                  div_in_valid, div_out_valid, res_valid;
   lbfi_pkg::div_type     div_in, div_out;
   lbfi_pkg::result_type  res;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_lo <= '0;
         cfg_ff.box_hi <= {3{32'h0001_0000}};
         cfg_ff.tol    <= 16'd1;
      end else if (wr) begin
         unique case (idx)
            lbfi_pkg::RegBoxLowX:  cfg_ff.box_lo[0] <= csr_pwdata;
            lbfi_pkg::RegBoxLowY:  cfg_ff.box_lo[1] <= csr_pwdata;
            lbfi_pkg::RegBoxLowZ:  cfg_ff.box_lo[2] <= csr_pwdata;
            lbfi_pkg::RegBoxHighX: cfg_ff.box_hi[0] <= csr_pwdata;
            lbfi_pkg::RegBoxHighY: cfg_ff.box_hi[1] <= csr_pwdata;
            lbfi_pkg::RegBoxHighZ: cfg_ff.box_hi[2] <= csr_pwdata;
            lbfi_pkg::RegTol:      cfg_ff.tol       <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         lbfi_pkg::RegBoxLowX:  csr_prdata = cfg_ff.box_lo[0];
         lbfi_pkg::RegBoxLowY:  csr_prdata = cfg_ff.box_lo[1];
         lbfi_pkg::RegBoxLowZ:  csr_prdata = cfg_ff.box_lo[2];
         lbfi_pkg::RegBoxHighX: csr_prdata = cfg_ff.box_hi[0];
         lbfi_pkg::RegBoxHighY: csr_prdata = cfg_ff.box_hi[1];
         lbfi_pkg::RegBoxHighZ: csr_prdata = cfg_ff.box_hi[2];
         lbfi_pkg::RegTol:      csr_prdata = {16'b0, cfg_ff.tol};
         default:               csr_prdata = '0;
      endcase
   end

   lbfi_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .div_valid  (div_in_valid),
      .div_out    (div_in)
   );

   lbfi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_in_valid),
      .in_data   (div_in),
      .out_valid (div_out_valid),
      .out_data  (div_out)
   );

   lbfi_hit u_hit (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (div_out_valid),
      .in_data   (div_out),
      .res_valid (res_valid),
      .res       (res)
   );

   lbfi_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .res_valid  (res_valid),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for line_box_face_intersect: random and directed rays checked against a predictor.
`timescale 1ns / 100ps
module tb_top;
   localparam longint ONE  = 65536;
   localparam longint HALF = 32768;
   localparam longint PMAX = 64'sh7fffffff;
   localparam longint NMIN = -64'sh80000000;

   typedef struct {
      logic        hit;
      logic [2:0]  face;
      logic [31:0] x, y, z;
      logic        last;
   } hit_rec;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [191:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [4:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   logic [191:0]  ray_q[$];
   hit_rec        hit_q[$];
   longint        box_lo[3];
   longint        box_hi[3];
   longint        tol;
   int            mismatches = 0;
   bit            quiet = 1'b0;
   bit            hold = 1'b0;

   line_box_face_intersect uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_mag(longint unsigned mag, bit neg);
      if (neg) return (mag > 64'h80000000) ? NMIN : -longint'(mag);
      return (mag > 64'h7fffffff) ? PMAX : longint'(mag);
   endfunction

   function automatic longint sat32(longint v);
      return (v > PMAX) ? PMAX : (v < NMIN) ? NMIN : v;
   endfunction

   function automatic longint divide_fx(longint num, longint den);
      longint unsigned n, d, q, r;
      bit neg;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      q = n / d;
      r = n % d;
      if (q >= 32768) return clamp_mag(64'h80000000, neg);
      return clamp_mag((q << 16) | ((r << 16) / d), neg);
   endfunction

   function automatic longint multiply_fx(longint a, longint b);
      longint unsigned x, y;
      x = a < 0 ? -a : a;
      y = b < 0 ? -b : b;
      return clamp_mag((x * y) >> 16, (a < 0) != (b < 0));
   endfunction

   // faces in order zlow, zhigh, xlow, xhigh, ylow, yhigh
   task automatic predict_hits(logic [191:0] ray);
      int     axis_of[6] = '{2, 2, 0, 0, 1, 1};
      longint o[3], d[3], pos[3];
      longint p, num, t;
      int     a, found;
      bit     in_box;
      hit_rec h;
      found = 0;
      for (int k = 0; k < 3; k++) begin
         o[k] = longint'(signed'(ray[32*k +: 32]));
         d[k] = longint'(signed'(ray[96 + 32*k +: 32]));
      end
      for (int f = 0; f < 6; f++) begin
         a = axis_of[f];
         p = f[0] ? box_hi[a] : box_lo[a];
         if ((d[a] < 0 ? -d[a] : d[a]) <= tol) continue;
         num = p - o[a];
         if (num != 0 && ((num < 0) != (d[a] < 0))) continue;
         t = divide_fx(num, d[a]);
         in_box = 1'b1;
         for (int k = 0; k < 3; k++) begin
            pos[k] = (k == a) ? p : sat32(o[k] + multiply_fx(t, d[k]));
            if (pos[k] < box_lo[k] - tol || pos[k] > box_hi[k] + tol) in_box = 1'b0;
         end
         if (!in_box) continue;
         h.hit = 1'b1;
         h.face = 3'(f);
         h.x = pos[0][31:0];
         h.y = pos[1][31:0];
         h.z = pos[2][31:0];
         h.last = 1'b0;
         hit_q = {hit_q, h};
         found++;
      end
      if (found == 0) begin
         h = '{1'b0, 3'd0, 32'd0, 32'd0, 32'd0, 1'b1};
         hit_q = {hit_q, h};
      end else begin
         hit_q[$].last = 1'b1;
      end
   endtask

   // driver
   always @(posedge clock) begin
      logic         nxt_valid;
      logic [191:0] nxt_data;
      nxt_valid = req_tvalid;
      nxt_data = req_tdata;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_hits(req_tdata);
            void'(ray_q.pop_front());
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && !hold && ray_q.size() > 0
             && (quiet || $urandom_range(99) >= 23)) begin
            nxt_valid = 1'b1;
            nxt_data = ray_q[0];
         end
      end
      req_tvalid <= nxt_valid;
      req_tdata <= nxt_data;
   end

   // monitor
   always @(posedge clock) begin
      hit_rec e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_tdata);
         end else begin
            e = hit_q.pop_front();
            if (rsp_tuser !== e.hit || rsp_tdata[2:0] !== e.face
                || rsp_tdata[34:3] !== e.x || rsp_tdata[66:35] !== e.y
                || rsp_tdata[98:67] !== e.z || rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp hit %b face %0d %h %h %h last %b, got %b %0d %h %h %h %b",
                     e.hit, e.face, e.x, e.y, e.z, e.last, rsp_tuser, rsp_tdata[2:0],
                     rsp_tdata[34:3], rsp_tdata[66:35], rsp_tdata[98:67], rsp_tlast);
            end
         end
      end
      rsp_tready <= quiet || $urandom_range(99) >= 23;
   end

   task automatic csr_write(logic [2:0] idx, longint val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val[31:0];
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         lbfi_pkg::RegBoxLowX, lbfi_pkg::RegBoxLowY, lbfi_pkg::RegBoxLowZ:
            box_lo[idx] = longint'(signed'(val[31:0]));
         lbfi_pkg::RegBoxHighX:  box_hi[0] = longint'(signed'(val[31:0]));
         lbfi_pkg::RegBoxHighY:  box_hi[1] = longint'(signed'(val[31:0]));
         lbfi_pkg::RegBoxHighZ:  box_hi[2] = longint'(signed'(val[31:0]));
         lbfi_pkg::RegTol:       tol = val & 64'hffff;
         default: ;
      endcase
   endtask

   task automatic set_box(longint lx, longint ly, longint lz, longint hx, longint hy,
                          longint hz, longint tl);
      csr_write(lbfi_pkg::RegBoxLowX, lx);
      csr_write(lbfi_pkg::RegBoxLowY, ly);
      csr_write(lbfi_pkg::RegBoxLowZ, lz);
      csr_write(lbfi_pkg::RegBoxHighX, hx);
      csr_write(lbfi_pkg::RegBoxHighY, hy);
      csr_write(lbfi_pkg::RegBoxHighZ, hz);
      csr_write(lbfi_pkg::RegTol, tl);
   endtask

   task automatic add_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                          longint dz);
      logic [191:0] r;
      r = {dz[31:0], dy[31:0], dx[31:0], oz[31:0], oy[31:0], ox[31:0]};
      ray_q = {ray_q, r};
   endtask

   task automatic wait_drained();
      wait (ray_q.size() == 0 && !req_tvalid && hit_q.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic longint any_coord();
      case ($urandom_range(5))
         0: return longint'(signed'($urandom()));
         1: return NMIN;
         2: return PMAX;
         3: return 0;
         default: return longint'($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
   endfunction

   task automatic add_random_rays(int count);
      longint tgt[3], o[3], d[3], span;
      int sh;
      repeat (count) begin
         if ($urandom_range(9) < 2) begin
            add_ray(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                    any_coord());
         end else begin
            sh = $urandom_range(0, 3);
            for (int k = 0; k < 3; k++) begin
               span = box_hi[k] - box_lo[k];
               tgt[k] = box_lo[k];
               if (span > 0) tgt[k] += (span / 1024) * $urandom_range(0, 1024);
               o[k] = sat32(tgt[k] + longint'($urandom_range(0, 1 << 19)) - (1 << 18));
               d[k] = sat32((tgt[k] - o[k]) >>> sh);
               if ($urandom_range(7) == 0) d[k] = 0;
            end
            add_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
         end
      end
   endtask

   initial begin
      box_lo = '{0, 0, 0};
      box_hi = '{ONE, ONE, ONE};
      tol = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_ray(HALF, HALF, -ONE, 0, 0, ONE);
      add_ray(HALF, HALF, 2*ONE, 0, 0, -ONE);
      add_ray(-ONE, HALF, HALF, ONE, 0, 0);
      add_ray(2*ONE, HALF, HALF, -ONE, 0, 0);
      add_ray(HALF, -ONE, HALF, 0, ONE, 0);
      add_ray(HALF, 2*ONE, HALF, 0, -ONE, 0);
      add_ray(HALF, HALF, HALF, 0, 0, 0);
      add_ray(HALF, HALF, -ONE, 1, 1, 1);
      add_ray(HALF, HALF, -ONE, 0, 0, -ONE);
      add_ray(0, 0, 0, ONE, ONE, ONE);
      add_ray(PMAX, PMAX, PMAX, NMIN, NMIN, NMIN);
      add_ray(NMIN, NMIN, NMIN, PMAX, PMAX, PMAX);
      add_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE);
      add_ray(HALF, HALF, NMIN, 0, 0, 1 << 4);
      add_ray(HALF, HALF, -ONE, PMAX, NMIN, 2);
      add_ray(HALF, -HALF, HALF, 0, ONE, 0);
      wait_drained();

      csr_write(3'd7, 12345);
      set_box(-2*ONE, -ONE, -3*ONE, 3*ONE, ONE, 0, 0);
      add_ray(HALF, 0, -5*ONE, 0, 0, ONE);
      add_ray(HALF, 0, -ONE, 0, 1, 0);
      quiet = 1'b1;
      add_random_rays(60);
      wait_drained();
      quiet = 1'b0;

      set_box(NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, 65535);
      add_ray(0, 0, 0, ONE, -ONE, 3);
      add_ray(PMAX, 0, NMIN, -1, 65535, 65536);
      add_random_rays(60);
      wait_drained();

      set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE, 100);
      add_random_rays(50);
      wait_drained();

      set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 1);
      add_random_rays(40);
      wait (ray_q.size() < 20);
      hold = 1'b1;
      wait (!req_tvalid && hit_q.size() == 0);
      hold = 1'b0;
      add_random_rays(40);
      wait_drained();

      set_box(longint'(signed'($urandom())) >>> 8, -HALF, 0, 5*ONE, 7*ONE, 1 << 20,
              $urandom_range(0, 300));
      add_random_rays(50);
      wait_drained();

      if (mismatches == 0 && hit_q.size() == 0)
         $display("PASS line_box_face_intersect");
      else
         $display("FAIL line_box_face_intersect");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL line_box_face_intersect");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lbfi_pkg.sv
rtl/core/lbfi_prep.sv
rtl/core/lbfi_div.sv
rtl/core/lbfi_hit.sv
rtl/core/lbfi_collect.sv
rtl/core/line_box_face_intersect.sv
dv/tb_top.sv
